// ===== rtl/core/acc_tilt_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table of the tilt-angle block.
package acc_tilt_pkg;

  localparam int SAMPLE_W        = 10;
  localparam int SUM_W           = 16;
  localparam int DEG_W           = 8;
  localparam int SQ_W            = 2 * SUM_W;
  localparam int ROOT_W          = SUM_W;
  localparam int CORDIC_STEPS    = 15;
  localparam int STEP_W          = 4;
  localparam int SCALE_SHIFT     = 16;
  localparam int CX_W            = 36;
  localparam int ANG_W           = 18;
  localparam int FRAC_BITS       = 8;
  localparam int DEFAULT_SAMPLES = 10;
  localparam int MAX_DEGREES     = 180;

  localparam logic signed [ANG_W-1:0] DEG90_Q8  = 18'sd23040;
  localparam logic signed [ANG_W-1:0] DEG180_Q8 = 18'sd46080;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT_GO,
    ST_SQRT,
    ST_CORDIC,
    ST_FINISH
  } state_t;

  // atan(2^-i) in degrees with 8 fractional bits, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q8(input logic [STEP_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      4'd0:    val = 18'sd11520;
      4'd1:    val = 18'sd6801;
      4'd2:    val = 18'sd3593;
      4'd3:    val = 18'sd1824;
      4'd4:    val = 18'sd916;
      4'd5:    val = 18'sd458;
      4'd6:    val = 18'sd229;
      4'd7:    val = 18'sd115;
      4'd8:    val = 18'sd57;
      4'd9:    val = 18'sd29;
      4'd10:   val = 18'sd14;
      4'd11:   val = 18'sd7;
      4'd12:   val = 18'sd4;
      4'd13:   val = 18'sd2;
      4'd14:   val = 18'sd1;
      default: val = 18'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/acc_tilt_in_if.sv =====
// Sample channel: valid/ready handshake carrying one x, y, z sample and a restart mark.
interface acc_tilt_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [acc_tilt_pkg::SAMPLE_W-1:0] accel_x;
  logic signed [acc_tilt_pkg::SAMPLE_W-1:0] accel_y;
  logic signed [acc_tilt_pkg::SAMPLE_W-1:0] accel_z;
  logic                                    restart;

  modport source (output valid, accel_x, accel_y, accel_z, restart, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, restart, output ready);
endinterface

// ===== rtl/core/acc_tilt_out_if.sv =====
// Result channel: valid/ready handshake carrying the tilt angle and the zero-vector flag.
interface acc_tilt_out_if;
  logic                             valid;
  logic                             ready;
  logic [acc_tilt_pkg::DEG_W-1:0]   tilt_degrees;
  logic                             zero_vector;

  modport source (output valid, tilt_degrees, zero_vector, input ready);
  modport sink   (input valid, tilt_degrees, zero_vector, output ready);
endinterface

// ===== rtl/core/accel_tilt_angle_core.sv =====
// Top level of the tilt-angle block: sample accumulation, squaring, sequencer and result register.
// Each accepted sample is added to three 16-bit running sums; restart reloads the
// sums with the sample. Every SAMPLES-th sample closes an average: the block then squares x and y
// on one 16x16 multiplier, takes the integer square root of x^2+y^2 (a launch state, then two
// bits a cycle), runs a 15-step vectoring CORDIC for atan2(r, z) in 1/256 degree, and places the
// truncated angle in the output register. Such a sample keeps the input not ready until the
// block is back in idle; a zero summed vector skips the arithmetic and reports zero_vector with
// angle 0. All other samples leave the block in idle. The result register holds the result
// until it is taken; the next result waits in the finish state while an earlier one is still held.
module accel_tilt_angle_core #(
  parameter int SAMPLES = acc_tilt_pkg::DEFAULT_SAMPLES
) (
  input  logic            clk,
  input  logic            rst,
  acc_tilt_in_if.sink     sample_in,
  acc_tilt_out_if.source  result_out
);
  import acc_tilt_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES + 1);

  state_t state;
  state_t state_next;

  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sum_z;
  logic [CNT_W-1:0]        sample_count;

  logic signed [SUM_W-1:0] sum_x_next;
  logic signed [SUM_W-1:0] sum_y_next;
  logic signed [SUM_W-1:0] sum_z_next;
  logic [CNT_W-1:0]        count_next;
  logic                    take;
  logic                    closes;
  logic                    vec_zero;

  logic signed [SUM_W-1:0] work_x;
  logic signed [SUM_W-1:0] work_y;
  logic signed [SUM_W-1:0] work_z;
  logic                    work_zero;
  logic [SQ_W-1:0]         sum_sq;
  logic signed [SUM_W-1:0] mul_a;
  logic signed [SQ_W-1:0]  prod;

  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [ROOT_W-1:0]       root;
  logic                    cordic_start;
  logic                    cordic_done;
  logic [DEG_W-1:0]        cordic_deg;
  logic                    load_result;

  assign take       = sample_in.valid && sample_in.ready;
  assign sum_x_next = (sample_in.restart ? SUM_W'(0) : sum_x) + SUM_W'(sample_in.accel_x);
  assign sum_y_next = (sample_in.restart ? SUM_W'(0) : sum_y) + SUM_W'(sample_in.accel_y);
  assign sum_z_next = (sample_in.restart ? SUM_W'(0) : sum_z) + SUM_W'(sample_in.accel_z);
  assign count_next = sample_in.restart ? CNT_W'(1) : sample_count + 1'b1;
  assign closes     = (count_next == CNT_W'(SAMPLES));
  assign vec_zero   = (sum_x_next == '0) && (sum_y_next == '0) && (sum_z_next == '0);

  // one shared squarer: x in state ST_SQ_X, y in state ST_SQ_Y
  assign mul_a = (state == ST_SQ_X) ? work_x : work_y;
  assign prod  = SQ_W'(mul_a) * SQ_W'(mul_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    sample_in.ready  = 1'b0;
    sqrt_start       = 1'b0;
    cordic_start     = 1'b0;
    load_result      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_in.ready = 1'b1;
        if (sample_in.valid && closes) begin
          state_next = vec_zero ? ST_FINISH : ST_SQ_X;
        end
      end
      ST_SQ_X: begin
        state_next = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        state_next = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          cordic_start = 1'b1;
          state_next   = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cordic_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!result_out.valid || result_out.ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      sample_count <= '0;
    end else if (take) begin
      if (closes) begin
        sum_x        <= '0;
        sum_y        <= '0;
        sum_z        <= '0;
        sample_count <= '0;
      end else begin
        sum_x        <= sum_x_next;
        sum_y        <= sum_y_next;
        sum_z        <= sum_z_next;
        sample_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && closes) begin
      work_x    <= sum_x_next;
      work_y    <= sum_y_next;
      work_z    <= sum_z_next;
      work_zero <= vec_zero;
    end
    if (state == ST_SQ_X) begin
      sum_sq <= SQ_W'(prod);
    end else if (state == ST_SQ_Y) begin
      sum_sq <= sum_sq + SQ_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (load_result) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result_out.tilt_degrees <= work_zero ? DEG_W'(0) : cordic_deg;
      result_out.zero_vector  <= work_zero;
    end
  end

  acc_tilt_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sum_sq),
    .root     (root),
    .done     (sqrt_done)
  );

  acc_tilt_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .r       (root),
    .z       (work_z),
    .degrees (cordic_deg),
    .done    (cordic_done)
  );

`ifndef SYNTH
  a_count_below: assert property (@(posedge clk) disable iff (rst)
    sample_count < CNT_W'(SAMPLES))
    else $error("sample count reached SAMPLES without closing the average");
  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.tilt_degrees <= DEG_W'(MAX_DEGREES))
    else $error("tilt above 180 degrees");
  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.zero_vector) |-> result_out.tilt_degrees == '0)
    else $error("zero vector reported with nonzero angle");
  a_sq_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQ_X |=> state == ST_SQ_Y)
    else $error("squaring sequence broken");
`endif

endmodule

// ===== rtl/core/acc_tilt_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module acc_tilt_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [acc_tilt_pkg::SQ_W-1:0]     radicand,
  output logic [acc_tilt_pkg::ROOT_W-1:0]   root,
  output logic                              done
);
  import acc_tilt_pkg::*;

  localparam int ITERS = SQ_W / 2;
  localparam int CNT_W = $clog2(ITERS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SQ_W-1:0]  rem;
  logic [SQ_W-1:0]  res;
  logic [SQ_W-1:0]  bit_pos;
  logic [SQ_W:0]    trial;
  logic             fits;

  assign trial = {1'b0, res} + {1'b0, bit_pos};
  assign fits  = ({1'b0, rem} >= trial);
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= radicand;
      res     <= '0;
      bit_pos <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + bit_pos;
      end else begin
        res <= res >> 1;
      end
      bit_pos <= bit_pos >> 2;
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("square root started while busy");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("square root done while still iterating");
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (res >> ROOT_W) == '0)
    else $error("square root result wider than root port");
`endif

endmodule

// ===== rtl/core/acc_tilt_cordic.sv =====
// Vectoring CORDIC: angle of (z, r) from the +z axis in degrees, one micro-rotation per cycle.
module acc_tilt_cordic (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [acc_tilt_pkg::ROOT_W-1:0]        r,
  input  logic signed [acc_tilt_pkg::SUM_W-1:0]  z,
  output logic [acc_tilt_pkg::DEG_W-1:0]         degrees,
  output logic                                   done
);
  import acc_tilt_pkg::*;

  logic                    busy;
  logic [STEP_W-1:0]       step;
  logic signed [CX_W-1:0]  cx;
  logic signed [CX_W-1:0]  cy;
  logic signed [ANG_W-1:0] ang;
  logic signed [CX_W-1:0]  dx;
  logic signed [CX_W-1:0]  dy;
  logic signed [CX_W-1:0]  r_ext;
  logic signed [CX_W-1:0]  z_ext;

  assign r_ext = CX_W'(r);
  assign z_ext = CX_W'(z);
  assign dx    = cy >>> step;
  assign dy    = cx >>> step;

  // clamp the residue into 0..180 degrees, then drop the fraction
  always_comb begin
    if (ang < 0) begin
      degrees = '0;
    end else if (ang > DEG180_Q8) begin
      degrees = DEG_W'(MAX_DEGREES);
    end else begin
      degrees = ang[FRAC_BITS +: DEG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // rotate a negative z (the left half-plane) into the first quadrant
      if (z < 0) begin
        cx  <= r_ext <<< SCALE_SHIFT;
        cy  <= (-z_ext) <<< SCALE_SHIFT;
        ang <= DEG90_Q8;
      end else begin
        cx  <= z_ext <<< SCALE_SHIFT;
        cy  <= r_ext <<< SCALE_SHIFT;
        ang <= '0;
      end
    end else if (busy) begin
      if (cy > 0) begin
        cx  <= cx + dx;
        cy  <= cy - dy;
        ang <= ang + atan_q8(step);
      end else begin
        cx  <= cx - dx;
        cy  <= cy + dy;
        ang <= ang - atan_q8(step);
      end
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("CORDIC started while busy");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step < STEP_W'(CORDIC_STEPS))
    else $error("CORDIC step past last micro-rotation");
  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    done |-> degrees <= DEG_W'(MAX_DEGREES))
    else $error("CORDIC angle above 180 degrees");
`endif

endmodule
